[sv/svpwm_pkg.sv]
// Shared widths, polynomial coefficients and sector codes for the SVPWM duty unit.
package svpwm_pkg;

	localparam int ANGLE_BITS = 16;
	localparam int FRAC_BITS  = 16;

	// Fixed point of the sine polynomial and the width of its operands.
	localparam int KQ = 30;
	localparam int XW = KQ + 1;

	// Widths of the magnitude, the active times, the doubled sums and the duties.
	localparam int MW = FRAC_BITS + 1;
	localparam int TW = FRAC_BITS + 1;
	localparam int SW = FRAC_BITS + 4;
	localparam int DW = FRAC_BITS + 2;
	localparam int PW = MW + XW;

	// Odd Taylor coefficients of (2/sqrt3)*sin(x*pi/3), Q30.
	localparam logic [XW-1:0] K1 = XW'(1298368158);
	localparam logic [XW-1:0] K3 = XW'(237303335);
	localparam logic [XW-1:0] K5 = XW'(13011611);
	localparam logic [XW-1:0] K7 = XW'(339734);
	localparam logic [XW-1:0] K9 = XW'(5175);

	// Latency from an accepted start to the result strobe.
	localparam int PIPE_LAT = 9;

	typedef enum logic [2:0] {
		SECTOR_0 = 3'd0,
		SECTOR_1 = 3'd1,
		SECTOR_2 = 3'd2,
		SECTOR_3 = 3'd3,
		SECTOR_4 = 3'd4,
		SECTOR_5 = 3'd5
	} sector_t;

	// Values that ride alongside the sine lanes.
	typedef struct packed {
		sector_t       sector;
		logic [MW-1:0] mag;
	} side_t;

endpackage

[sv/svpwm_sine_lane.sv]
// Six-stage pipelined evaluation of the scaled sine polynomial for one lane.
module svpwm_sine_lane
	import svpwm_pkg::*;
(
	input  logic          clk,
	input  logic [XW-1:0] x,
	output logic [XW-1:0] g
);

	// Product of two Q30 operands, brought back to Q30.
	function automatic logic [XW-1:0] mul_q(input logic [XW-1:0] a, input logic [XW-1:0] b);
		logic [2*XW-1:0] p;
		p = a * b;
		return p[KQ+XW-1:KQ];
	endfunction

	logic [XW-1:0] x_s2, x_s3, x_s4, x_s5, x_s6;
	logic [XW-1:0] x2_s2, x2_s3, x2_s4, x2_s5;
	logic [XW-1:0] t_s3, t_s4, t_s5, t_s6;
	logic [XW-1:0] g_s7;

	// Horner steps from the highest coefficient down, one multiply per stage.
	always_ff @(posedge clk) begin
		x_s2  <= x;
		x2_s2 <= mul_q(x, x);

		x_s3  <= x_s2;
		x2_s3 <= x2_s2;
		t_s3  <= K7 - mul_q(x2_s2, K9);

		x_s4  <= x_s3;
		x2_s4 <= x2_s3;
		t_s4  <= K5 - mul_q(x2_s3, t_s3);

		x_s5  <= x_s4;
		x2_s5 <= x2_s4;
		t_s5  <= K3 - mul_q(x2_s4, t_s4);

		x_s6  <= x_s5;
		t_s6  <= K1 - mul_q(x2_s5, t_s5);

		g_s7  <= mul_q(x_s6, t_s6);
	end

	assign g = g_s7;

endmodule

[sv/space_vector_pwm_duty_unit.sv]
// Top level of the center-aligned space vector PWM duty unit.
//
//  channel   signals                                   direction  handshake
//  -------   ---------------------------------------   ---------  ----------------------
//  command   start, busy, angle, magnitude             in         taken when start & !busy
//  result    valid, duty_phase_a/b/c                   out        one-cycle strobe on valid
//
// Every item is registered at each stage from the accepting edge to its result strobe; the depth
// is set by the two sine lanes, which chain six multiplies, followed by the scaling
// multiply and the duty assembly stage. A new item can be taken at every clock edge.
// busy is held low: the pipeline never stalls, and the receiver cannot stall it either.
// Reset clears only the valid bits; data registers hold whatever they held.
module space_vector_pwm_duty_unit
	import svpwm_pkg::*;
(
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	output logic                        busy,
	input  logic        [ANGLE_BITS-1:0] angle,
	input  logic signed [DW-1:0]         magnitude,
	output logic                        valid,
	output logic signed [DW-1:0]         duty_phase_a,
	output logic signed [DW-1:0]         duty_phase_b,
	output logic signed [DW-1:0]         duty_phase_c
);

	localparam logic [MW-1:0] MAG_ONE = MW'(1) << FRAC_BITS;
	localparam logic [XW-1:0] X_ONE   = XW'(1) << KQ;
	localparam logic [PW-1:0] T_HALF  = PW'(1) << (KQ - 1);

	// Nothing in the datapath ever holds an item back.
	assign busy = 1'b0;

	logic accept;
	assign accept = start & ~busy;

	// ---------------------------------------------------------------------------------
	// Front end: sector split and magnitude clamp.
	// angle*6 puts the sector in the three top bits and the position within the sector
	// in the low ANGLE_BITS bits. A boundary angle lands in the higher sector with u = 0.
	// ---------------------------------------------------------------------------------
	logic [ANGLE_BITS+2:0] ang6;
	logic [ANGLE_BITS-1:0] pos;
	logic [XW-1:0]         x_lead;
	logic [MW-1:0]         mag_clamped;

	assign ang6   = ({3'b000, angle} << 2) + ({3'b000, angle} << 1);
	assign pos    = ang6[ANGLE_BITS-1:0];
	assign x_lead = XW'(pos) << (KQ - ANGLE_BITS);

	always_comb begin
		if (magnitude[DW-1]) begin
			mag_clamped = '0;
		end else if (magnitude[DW-2:0] > MAG_ONE) begin
			mag_clamped = MAG_ONE;
		end else begin
			mag_clamped = magnitude[DW-2:0];
		end
	end

	logic          vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6, vld_s7, vld_s8, vld_s9;
	side_t         side_s1, side_s2, side_s3, side_s4, side_s5, side_s6, side_s7;
	logic [XW-1:0] xa_s1, xb_s1;

	always_ff @(posedge clk) begin
		side_s1.sector <= sector_t'(ang6[ANGLE_BITS+2:ANGLE_BITS]);
		side_s1.mag    <= mag_clamped;
		// xa gives T2 (the sine of u), xb gives T1 (the sine of 1-u).
		xa_s1          <= x_lead;
		xb_s1          <= X_ONE - x_lead;
	end

	// ---------------------------------------------------------------------------------
	// Sine lanes, stages 2 through 7.
	// ---------------------------------------------------------------------------------
	logic [XW-1:0] g1_s7, g2_s7;

	svpwm_sine_lane u_lane_t1 (
		.clk (clk),
		.x   (xb_s1),
		.g   (g1_s7)
	);

	svpwm_sine_lane u_lane_t2 (
		.clk (clk),
		.x   (xa_s1),
		.g   (g2_s7)
	);

	// The sector and the magnitude follow the lanes stage by stage.
	always_ff @(posedge clk) begin
		side_s2 <= side_s1;
		side_s3 <= side_s2;
		side_s4 <= side_s3;
		side_s5 <= side_s4;
		side_s6 <= side_s5;
		side_s7 <= side_s6;
	end

	// ---------------------------------------------------------------------------------
	// Stage 8: active times, T = m*g in Q30 rounded half up to the duty fraction.
	// ---------------------------------------------------------------------------------
	logic [PW-1:0] prod1, prod2;
	logic [TW-1:0] t1_s8, t2_s8;
	sector_t       sector_s8;

	assign prod1 = PW'(side_s7.mag) * PW'(g1_s7) + T_HALF;
	assign prod2 = PW'(side_s7.mag) * PW'(g2_s7) + T_HALF;

	always_ff @(posedge clk) begin
		t1_s8     <= prod1[KQ+TW-1:KQ];
		t2_s8     <= prod2[KQ+TW-1:KQ];
		sector_s8 <= side_s7.sector;
	end

	// ---------------------------------------------------------------------------------
	// Stage 9: zero time and the three duty levels, then routing by sector.
	// Each level is a doubled sum halved with rounding half up, which for both signs is
	// an arithmetic shift of the sum plus one. Overmodulated duties are passed unclamped.
	// ---------------------------------------------------------------------------------
	logic signed [SW-1:0] t1_w, t2_w, t0_w;
	logic signed [SW-1:0] lag_w, mid1_w, mid2_w, lead_w;
	logic signed [DW-1:0] lag_d, mid1_d, mid2_d, lead_d;
	logic signed [DW-1:0] da_w, db_w, dc_w;

	always_comb begin
		t1_w   = signed'(SW'(t1_s8));
		t2_w   = signed'(SW'(t2_s8));
		t0_w   = signed'(SW'(MAG_ONE)) - t1_w - t2_w;
		lag_w  = (t0_w + SW'(1)) >>> 1;
		mid1_w = (t0_w + (t1_w <<< 1) + SW'(1)) >>> 1;
		mid2_w = (t0_w + (t2_w <<< 1) + SW'(1)) >>> 1;
		lead_w = (t0_w + (t1_w <<< 1) + (t2_w <<< 1) + SW'(1)) >>> 1;
		lag_d  = lag_w[DW-1:0];
		mid1_d = mid1_w[DW-1:0];
		mid2_d = mid2_w[DW-1:0];
		lead_d = lead_w[DW-1:0];

		unique case (sector_s8)
			SECTOR_0: begin
				da_w = lead_d; db_w = mid2_d; dc_w = lag_d;
			end
			SECTOR_1: begin
				da_w = mid1_d; db_w = lead_d; dc_w = lag_d;
			end
			SECTOR_2: begin
				da_w = lag_d;  db_w = lead_d; dc_w = mid2_d;
			end
			SECTOR_3: begin
				da_w = lag_d;  db_w = mid1_d; dc_w = lead_d;
			end
			SECTOR_4: begin
				da_w = mid2_d; db_w = lag_d;  dc_w = lead_d;
			end
			default: begin
				da_w = lead_d; db_w = lag_d;  dc_w = mid1_d;
			end
		endcase
	end

	logic signed [DW-1:0] da_s9, db_s9, dc_s9;

	always_ff @(posedge clk) begin
		da_s9 <= da_w;
		db_s9 <= db_w;
		dc_s9 <= dc_w;
	end

	// Valid bits travel with the data through all nine stages.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
			vld_s7 <= 1'b0;
			vld_s8 <= 1'b0;
			vld_s9 <= 1'b0;
		end else begin
			vld_s1 <= accept;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
			vld_s6 <= vld_s5;
			vld_s7 <= vld_s6;
			vld_s8 <= vld_s7;
			vld_s9 <= vld_s8;
		end
	end

	assign valid        = vld_s9;
	assign duty_phase_a = da_s9;
	assign duty_phase_b = db_s9;
	assign duty_phase_c = dc_s9;

`ifndef SYNTHESIS
	// Every accepted item yields a result strobe.
	a_item_to_result: assert property (@(posedge clk) disable iff (!arst_n)
		accept |-> ##PIPE_LAT valid)
		else $error("accepted item produced no result strobe");

	// No strobe appears without a matching accepted item.
	a_result_from_item: assert property (@(posedge clk) disable iff (!arst_n)
		valid |-> $past(accept, PIPE_LAT))
		else $error("result strobe without a matching accepted item");

	// The angle split never yields a sector code beyond five.
	a_sector_range: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s1 |-> (side_s1.sector <= SECTOR_5))
		else $error("sector code out of range");
`endif

endmodule
